// File: hw/rtl/dpalu_pkg.sv
// Shared constants, codes and pipeline types for the data-processing ALU.
package dpalu_pkg;

  localparam int DATA_W = 32;
  localparam int OPC_W  = 4;
  localparam int COND_W = 4;
  localparam int FLAG_W = 4;
  localparam int STAT_W = 2;

  // NZCV bit positions
  localparam int FLAG_N = 3;
  localparam int FLAG_Z = 2;
  localparam int FLAG_C = 1;
  localparam int FLAG_V = 0;

  // opcodes
  localparam logic [OPC_W-1:0] OP_AND = 4'd0;
  localparam logic [OPC_W-1:0] OP_EOR = 4'd1;
  localparam logic [OPC_W-1:0] OP_SUB = 4'd2;
  localparam logic [OPC_W-1:0] OP_RSB = 4'd3;
  localparam logic [OPC_W-1:0] OP_ADD = 4'd4;
  localparam logic [OPC_W-1:0] OP_ADC = 4'd5;
  localparam logic [OPC_W-1:0] OP_SBC = 4'd6;
  localparam logic [OPC_W-1:0] OP_RSC = 4'd7;
  localparam logic [OPC_W-1:0] OP_TST = 4'd8;
  localparam logic [OPC_W-1:0] OP_TEQ = 4'd9;
  localparam logic [OPC_W-1:0] OP_CMP = 4'd10;
  localparam logic [OPC_W-1:0] OP_CMN = 4'd11;
  localparam logic [OPC_W-1:0] OP_ORR = 4'd12;
  localparam logic [OPC_W-1:0] OP_MOV = 4'd13;
  localparam logic [OPC_W-1:0] OP_BIC = 4'd14;
  localparam logic [OPC_W-1:0] OP_MVN = 4'd15;

  // condition codes
  localparam logic [COND_W-1:0] COND_EQ = 4'd0;
  localparam logic [COND_W-1:0] COND_NE = 4'd1;
  localparam logic [COND_W-1:0] COND_CS = 4'd2;
  localparam logic [COND_W-1:0] COND_CC = 4'd3;
  localparam logic [COND_W-1:0] COND_MI = 4'd4;
  localparam logic [COND_W-1:0] COND_PL = 4'd5;
  localparam logic [COND_W-1:0] COND_VS = 4'd6;
  localparam logic [COND_W-1:0] COND_VC = 4'd7;
  localparam logic [COND_W-1:0] COND_HI = 4'd8;
  localparam logic [COND_W-1:0] COND_LS = 4'd9;
  localparam logic [COND_W-1:0] COND_GE = 4'd10;
  localparam logic [COND_W-1:0] COND_LT = 4'd11;
  localparam logic [COND_W-1:0] COND_GT = 4'd12;
  localparam logic [COND_W-1:0] COND_LE = 4'd13;
  localparam logic [COND_W-1:0] COND_AL = 4'd14;
  localparam logic [COND_W-1:0] COND_NV = 4'd15;

  // status codes
  localparam logic [STAT_W-1:0] ST_SKIP = 2'd0;
  localparam logic [STAT_W-1:0] ST_OK   = 2'd1;
  localparam logic [STAT_W-1:0] ST_PC   = 2'd2;

  // control handed to the execute unit
  typedef struct packed {
    logic [OPC_W-1:0] kind;
    logic             arith;
    logic             cin;
  } alu_ctl_t;

  // decode -> execute stage
  typedef struct packed {
    logic              pass;
    logic              upd;
    logic              test;
    logic              pc;
    logic              sc;
    logic [FLAG_W-1:0] fin;
    alu_ctl_t          ctl;
    logic [DATA_W-1:0] opa;
    logic [DATA_W-1:0] opb;
    logic [DATA_W-1:0] add_a;
    logic [DATA_W-1:0] add_b;
  } s1_t;

  // execute -> flags stage
  typedef struct packed {
    logic              pass;
    logic              upd;
    logic              test;
    logic              pc;
    logic              sc;
    logic              arith;
    logic [FLAG_W-1:0] fin;
    logic [DATA_W-1:0] res;
    logic              c;
    logic              v;
  } s2_t;

endpackage

// File: hw/rtl/dpalu_if.sv
// Channel interfaces: instruction in, result out.
interface dpalu_in_if;
  logic                          valid;
  logic                          ready;
  logic [dpalu_pkg::OPC_W-1:0]   kind;
  logic [dpalu_pkg::COND_W-1:0]  cond;
  logic                          set_flags;
  logic [dpalu_pkg::DATA_W-1:0]  first_operand;
  logic [dpalu_pkg::DATA_W-1:0]  second_operand;
  logic                          shifter_carry;
  logic [dpalu_pkg::FLAG_W-1:0]  flags_in;
  logic                          dest_is_pc;

  modport source (
    output valid, kind, cond, set_flags, first_operand, second_operand,
           shifter_carry, flags_in, dest_is_pc,
    input  ready
  );
  modport sink (
    input  valid, kind, cond, set_flags, first_operand, second_operand,
           shifter_carry, flags_in, dest_is_pc,
    output ready
  );
endinterface

interface dpalu_out_if;
  logic                          valid;
  logic                          ready;
  logic [dpalu_pkg::DATA_W-1:0]  result;
  logic                          write_back;
  logic [dpalu_pkg::FLAG_W-1:0]  flags_out;
  logic [dpalu_pkg::STAT_W-1:0]  status;

  modport source (
    output valid, result, write_back, flags_out, status,
    input  ready
  );
  modport sink (
    input  valid, result, write_back, flags_out, status,
    output ready
  );
endinterface

// File: hw/rtl/dpalu_exec.sv
// Execute unit: 32-bit adder with carry/overflow and the logic operations.
module dpalu_exec (
  input  dpalu_pkg::alu_ctl_t          ctl,
  input  logic [dpalu_pkg::DATA_W-1:0] opa,
  input  logic [dpalu_pkg::DATA_W-1:0] opb,
  input  logic [dpalu_pkg::DATA_W-1:0] add_a,
  input  logic [dpalu_pkg::DATA_W-1:0] add_b,
  output logic [dpalu_pkg::DATA_W-1:0] res,
  output logic                         c,
  output logic                         v
);
  import dpalu_pkg::*;

  logic [DATA_W:0]   sum;
  logic [DATA_W-1:0] sum_lo;
  logic [DATA_W-1:0] log_res;

  assign sum    = {1'b0, add_a} + {1'b0, add_b} + {{DATA_W{1'b0}}, ctl.cin};
  assign sum_lo = sum[DATA_W-1:0];
  assign c      = sum[DATA_W];
  // signed overflow: both addends differ in sign from the sum
  assign v      = (add_a[DATA_W-1] ^ sum_lo[DATA_W-1]) & (add_b[DATA_W-1] ^ sum_lo[DATA_W-1]);

  always_comb begin
    unique case (ctl.kind)
      OP_AND, OP_TST: log_res = opa & opb;
      OP_EOR, OP_TEQ: log_res = opa ^ opb;
      OP_ORR:         log_res = opa | opb;
      OP_MOV:         log_res = opb;
      OP_BIC:         log_res = opa & ~opb;
      OP_MVN:         log_res = ~opb;
      default:        log_res = sum_lo;
    endcase
  end

  assign res = ctl.arith ? sum_lo : log_res;

endmodule

// File: hw/rtl/arm_data_processing_alu_unit.sv
// ARM data-processing ALU, three-stage pipeline with NZCV flag generation.
// An accepted transaction passes the decode, execute and flag registers to out_chan.
// Throughput: one transaction per cycle while out_chan is ready; the decode,
//   execute and flag stages hold one instruction each; a full one advances when the next frees.
// Reset (rst_n low, synchronous) empties all stages; payload is not cleared.
module arm_data_processing_alu_unit (
  input logic         clk,
  input logic         rst_n,
  dpalu_in_if.sink    in_chan,
  dpalu_out_if.source out_chan
);
  import dpalu_pkg::*;

  // --- stage occupancy and backpressure -------------------------------
  // Each stage takes new work when it is empty or its contents move on.
  logic v1_r, v2_r, v3_r;
  logic v1_nxt, v2_nxt, v3_nxt;
  logic rdy1, rdy2, rdy3;

  assign rdy3 = !v3_r || out_chan.ready;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  assign in_chan.ready = rdy1;

  assign v1_nxt = rdy1 ? in_chan.valid : v1_r;
  assign v2_nxt = rdy2 ? v1_r : v2_r;
  assign v3_nxt = rdy3 ? v2_r : v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  // --- stage 1: condition check and operand steering ------------------
  logic fn, fz, fc, fv;
  logic pass;
  s1_t  s1_nxt, s1_r;

  assign fn = in_chan.flags_in[FLAG_N];
  assign fz = in_chan.flags_in[FLAG_Z];
  assign fc = in_chan.flags_in[FLAG_C];
  assign fv = in_chan.flags_in[FLAG_V];

  always_comb begin
    unique case (in_chan.cond)
      COND_EQ: pass = fz;
      COND_NE: pass = !fz;
      COND_CS: pass = fc;
      COND_CC: pass = !fc;
      COND_MI: pass = fn;
      COND_PL: pass = !fn;
      COND_VS: pass = fv;
      COND_VC: pass = !fv;
      COND_HI: pass = fc && !fz;
      COND_LS: pass = !fc || fz;
      COND_GE: pass = (fn == fv);
      COND_LT: pass = (fn != fv);
      COND_GT: pass = !fz && (fn == fv);
      COND_LE: pass = fz || (fn != fv);
      COND_AL: pass = 1'b1;
      COND_NV: pass = 1'b0;
    endcase
  end

  // Subtracts are a + ~b + carry-in; reverse forms swap the operands.
  // Carry-in is 1 for plain subtract, the C flag for the with-carry forms.
  always_comb begin
    s1_nxt.pass     = pass;
    s1_nxt.test     = (in_chan.kind == OP_TST) || (in_chan.kind == OP_TEQ) ||
                      (in_chan.kind == OP_CMP) || (in_chan.kind == OP_CMN);
    s1_nxt.upd      = in_chan.set_flags || s1_nxt.test;
    s1_nxt.pc       = in_chan.dest_is_pc;
    s1_nxt.sc       = in_chan.shifter_carry;
    s1_nxt.fin      = in_chan.flags_in;
    s1_nxt.ctl.kind = in_chan.kind;
    s1_nxt.opa      = in_chan.first_operand;
    s1_nxt.opb      = in_chan.second_operand;
    unique case (in_chan.kind)
      OP_SUB, OP_CMP: begin
        s1_nxt.ctl.arith = 1'b1;
        s1_nxt.ctl.cin   = 1'b1;
        s1_nxt.add_a     = in_chan.first_operand;
        s1_nxt.add_b     = ~in_chan.second_operand;
      end
      OP_RSB: begin
        s1_nxt.ctl.arith = 1'b1;
        s1_nxt.ctl.cin   = 1'b1;
        s1_nxt.add_a     = in_chan.second_operand;
        s1_nxt.add_b     = ~in_chan.first_operand;
      end
      OP_ADD, OP_CMN: begin
        s1_nxt.ctl.arith = 1'b1;
        s1_nxt.ctl.cin   = 1'b0;
        s1_nxt.add_a     = in_chan.first_operand;
        s1_nxt.add_b     = in_chan.second_operand;
      end
      OP_ADC: begin
        s1_nxt.ctl.arith = 1'b1;
        s1_nxt.ctl.cin   = fc;
        s1_nxt.add_a     = in_chan.first_operand;
        s1_nxt.add_b     = in_chan.second_operand;
      end
      OP_SBC: begin
        s1_nxt.ctl.arith = 1'b1;
        s1_nxt.ctl.cin   = fc;
        s1_nxt.add_a     = in_chan.first_operand;
        s1_nxt.add_b     = ~in_chan.second_operand;
      end
      OP_RSC: begin
        s1_nxt.ctl.arith = 1'b1;
        s1_nxt.ctl.cin   = fc;
        s1_nxt.add_a     = in_chan.second_operand;
        s1_nxt.add_b     = ~in_chan.first_operand;
      end
      default: begin
        // logic ops: adder idle
        s1_nxt.ctl.arith = 1'b0;
        s1_nxt.ctl.cin   = 1'b0;
        s1_nxt.add_a     = in_chan.first_operand;
        s1_nxt.add_b     = in_chan.second_operand;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_chan.valid) begin
      s1_r <= s1_nxt;
    end
  end

  // --- stage 2: add / logic ------------------------------------------
  logic [DATA_W-1:0] ex_res;
  logic              ex_c, ex_v;
  s2_t               s2_nxt, s2_r;

  dpalu_exec u_exec (
    .ctl   (s1_r.ctl),
    .opa   (s1_r.opa),
    .opb   (s1_r.opb),
    .add_a (s1_r.add_a),
    .add_b (s1_r.add_b),
    .res   (ex_res),
    .c     (ex_c),
    .v     (ex_v)
  );

  always_comb begin
    s2_nxt.pass  = s1_r.pass;
    s2_nxt.upd   = s1_r.upd;
    s2_nxt.test  = s1_r.test;
    s2_nxt.pc    = s1_r.pc;
    s2_nxt.sc    = s1_r.sc;
    s2_nxt.arith = s1_r.ctl.arith;
    s2_nxt.fin   = s1_r.fin;
    s2_nxt.res   = ex_res;
    s2_nxt.c     = ex_c;
    s2_nxt.v     = ex_v;
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      s2_r <= s2_nxt;
    end
  end

  // --- stage 3: flags, write-back, status; doubles as output register -
  // Logical ops take C from the shifter and keep V. A skipped instruction
  // gives a zero result with flags passed through untouched.
  logic [DATA_W-1:0] result_nxt, result_r;
  logic              wb_nxt, wb_r;
  logic [FLAG_W-1:0] flags_nxt, flags_r;
  logic [STAT_W-1:0] status_nxt, status_r;
  logic [FLAG_W-1:0] new_flags;

  always_comb begin
    new_flags[FLAG_N] = s2_r.res[DATA_W-1];
    new_flags[FLAG_Z] = (s2_r.res == '0);
    new_flags[FLAG_C] = s2_r.arith ? s2_r.c : s2_r.sc;
    new_flags[FLAG_V] = s2_r.arith ? s2_r.v : s2_r.fin[FLAG_V];
  end

  always_comb begin
    if (!s2_r.pass) begin
      result_nxt = '0;
      wb_nxt     = 1'b0;
      flags_nxt  = s2_r.fin;
      status_nxt = ST_SKIP;
    end else begin
      result_nxt = s2_r.res;
      wb_nxt     = !s2_r.test;
      flags_nxt  = s2_r.upd ? new_flags : s2_r.fin;
      status_nxt = (!s2_r.test && s2_r.pc) ? ST_PC : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      result_r <= result_nxt;
      wb_r     <= wb_nxt;
      flags_r  <= flags_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_chan.valid      = v3_r;
  assign out_chan.result     = result_r;
  assign out_chan.write_back = wb_r;
  assign out_chan.flags_out  = flags_r;
  assign out_chan.status     = status_r;

endmodule

// File: tb/arm_data_processing_alu_unit_tb.sv
// Self-checking testbench for the ARM data-processing ALU: directed table, then random traffic.
`timescale 1ns / 1ps

module arm_data_processing_alu_unit_tb;
  import dpalu_pkg::*;

  localparam int RAND_ITEMS     = 1150;
  localparam int DIR_ROWS       = 24;
  // Longest run of cycles with no transaction on either side before we give up.
  // The deliberate sink hold-off is set by HOLD_CYCLES, so this leaves plenty of margin.
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int HOLD_CYCLES    = 200;
  // Pipeline is three deep; let extra edges pass at the end to catch strays.
  localparam int DRAIN_CYCLES   = 8;

  // One instruction as offered on in_chan.
  typedef struct packed {
    logic [OPC_W-1:0]  kind;
    logic [COND_W-1:0] cond;
    logic              set_flags;
    logic [DATA_W-1:0] first_operand;
    logic [DATA_W-1:0] second_operand;
    logic              shifter_carry;
    logic [FLAG_W-1:0] flags_in;
    logic              dest_is_pc;
  } instr_t;

  // One result as seen on out_chan.
  typedef struct packed {
    logic [DATA_W-1:0] result;
    logic              write_back;
    logic [FLAG_W-1:0] flags_out;
    logic [STAT_W-1:0] status;
  } alu_res_t;

  // Directed row: typed = 1 means the expected result is written out in the row,
  // otherwise it comes from the local ALU model.
  typedef struct packed {
    instr_t   ins;
    logic     typed;
    alu_res_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  dpalu_in_if  in_if ();
  dpalu_out_if out_if ();

  arm_data_processing_alu_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  // 2 ns period: 1 ns high, 1 ns low.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Results still owed by the block, oldest first.
  alu_res_t pending_results [$];
  alu_res_t want;

  int n_err = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_skipped = 0;
  int n_pc_writes = 0;
  int quiet_cycles = 0;

  // Idling controls shared between the stimulus thread and the sink process.
  bit src_idle_on = 1'b1;
  bit rx_stall_on = 1'b1;
  bit hold_req = 1'b0;
  int hold_left = 0;

  // ---------------------------------------------------------------------------
  // Directed table. Rows with readable answers (extremes, skipped conditions,
  // test ops aimed at the PC) carry the answer; the rest go through the model.
  // ---------------------------------------------------------------------------
  dir_row_t dir_tab [DIR_ROWS] = '{
    // AND of zeros, flags untouched without S
    '{'{OP_AND, COND_AL, 1'b0, 32'h0, 32'h0, 1'b0, 4'b0000, 1'b0},
      1'b1, '{32'h0, 1'b1, 4'b0000, ST_OK}},
    // MOV #0 with S: Z set, C from shifter, V kept
    '{'{OP_MOV, COND_AL, 1'b1, 32'h0, 32'h0, 1'b1, 4'b0001, 1'b0},
      1'b1, '{32'h0, 1'b1, 4'b0111, ST_OK}},
    // MVN #0 with S: all ones, N set
    '{'{OP_MVN, COND_AL, 1'b1, 32'h0, 32'h0, 1'b0, 4'b0000, 1'b0},
      1'b1, '{32'hFFFF_FFFF, 1'b1, 4'b1000, ST_OK}},
    // ADD wraps to zero: Z and C
    '{'{OP_ADD, COND_AL, 1'b1, 32'hFFFF_FFFF, 32'h1, 1'b0, 4'b0000, 1'b0},
      1'b1, '{32'h0, 1'b1, 4'b0110, ST_OK}},
    // ADD signed overflow: N and V
    '{'{OP_ADD, COND_AL, 1'b1, 32'h7FFF_FFFF, 32'h1, 1'b0, 4'b0000, 1'b0},
      1'b1, '{32'h8000_0000, 1'b1, 4'b1001, ST_OK}},
    // SUB 0 - 1 borrows, so C is clear
    '{'{OP_SUB, COND_AL, 1'b1, 32'h0, 32'h1, 1'b0, 4'b0000, 1'b0},
      1'b1, '{32'hFFFF_FFFF, 1'b1, 4'b1000, ST_OK}},
    // SUB most negative - 1: no borrow, signed overflow
    '{'{OP_SUB, COND_AL, 1'b1, 32'h8000_0000, 32'h1, 1'b0, 4'b0000, 1'b0},
      1'b1, '{32'h7FFF_FFFF, 1'b1, 4'b0011, ST_OK}},
    // CMP towards the PC: nothing written, status stays plain executed
    '{'{OP_CMP, COND_AL, 1'b0, 32'h5, 32'h5, 1'b0, 4'b1000, 1'b1},
      1'b1, '{32'h0, 1'b0, 4'b0110, ST_OK}},
    // TST towards the PC, C from shifter, V kept
    '{'{OP_TST, COND_AL, 1'b0, 32'hF0, 32'h0F, 1'b1, 4'b0001, 1'b1},
      1'b1, '{32'h0, 1'b0, 4'b0111, ST_OK}},
    '{'{OP_TEQ, COND_AL, 1'b0, 32'hFFFF_FFFF, 32'h1234_5678, 1'b0, 4'b1111, 1'b0},
      1'b0, '0},
    '{'{OP_CMN, COND_AL, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 4'b0000, 1'b0},
      1'b0, '0},
    '{'{OP_RSB, COND_AL, 1'b1, 32'h3, 32'h1, 1'b0, 4'b0000, 1'b0},
      1'b0, '0},
    '{'{OP_ADC, COND_AL, 1'b1, 32'hFFFF_FFFF, 32'h0, 1'b0, 4'b0010, 1'b0},
      1'b0, '0},
    '{'{OP_SBC, COND_AL, 1'b1, 32'h0, 32'h0, 1'b0, 4'b0000, 1'b0},
      1'b0, '0},
    '{'{OP_RSC, COND_AL, 1'b1, 32'h1, 32'h8000_0000, 1'b0, 4'b0010, 1'b0},
      1'b0, '0},
    '{'{OP_ORR, COND_AL, 1'b1, 32'h0000_FFFF, 32'hFFFF_0000, 1'b0, 4'b0000, 1'b1},
      1'b0, '0},
    '{'{OP_BIC, COND_AL, 1'b1, 32'hFFFF_FFFF, 32'h0F0F_0F0F, 1'b1, 4'b0001, 1'b0},
      1'b0, '0},
    '{'{OP_EOR, COND_AL, 1'b0, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 4'b0000, 1'b0},
      1'b0, '0},
    // condition never: skipped, flags pass through
    '{'{OP_ADD, COND_NV, 1'b1, 32'h1, 32'h1, 1'b1, 4'b1111, 1'b1},
      1'b1, '{32'h0, 1'b0, 4'b1111, ST_SKIP}},
    // EQ with Z clear: skipped
    '{'{OP_MOV, COND_EQ, 1'b1, 32'h0, 32'hDEAD_BEEF, 1'b0, 4'b0000, 1'b0},
      1'b1, '{32'h0, 1'b0, 4'b0000, ST_SKIP}},
    '{'{OP_MOV, COND_EQ, 1'b1, 32'h0, 32'h0, 1'b0, 4'b0100, 1'b1},
      1'b0, '0},
    // GE with N != V: skipped
    '{'{OP_SUB, COND_GE, 1'b1, 32'h9, 32'h3, 1'b0, 4'b1000, 1'b0},
      1'b1, '{32'h0, 1'b0, 4'b1000, ST_SKIP}},
    // no S bit: flags stay as they came in despite carry out
    '{'{OP_ADD, COND_AL, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 4'b0101, 1'b0},
      1'b1, '{32'hFFFF_FFFE, 1'b1, 4'b0101, ST_OK}},
    // MVN into the PC
    '{'{OP_MVN, COND_AL, 1'b0, 32'h0, 32'h0, 1'b0, 4'b0000, 1'b1},
      1'b1, '{32'hFFFF_FFFF, 1'b1, 4'b0000, ST_PC}}
  };

  // ---------------------------------------------------------------------------
  // ALU model: condition check, one of sixteen ops, NZCV update.
  // ---------------------------------------------------------------------------
  function automatic alu_res_t dp_execute(input instr_t t);
    alu_res_t o;
    logic n, z, c, v;
    logic pass, arith, is_test, cin;
    logic [DATA_W-1:0] x, y, r;
    logic [DATA_W:0] sum;

    n = t.flags_in[FLAG_N];
    z = t.flags_in[FLAG_Z];
    c = t.flags_in[FLAG_C];
    v = t.flags_in[FLAG_V];
    case (t.cond)
      COND_EQ: pass = z;
      COND_NE: pass = !z;
      COND_CS: pass = c;
      COND_CC: pass = !c;
      COND_MI: pass = n;
      COND_PL: pass = !n;
      COND_VS: pass = v;
      COND_VC: pass = !v;
      COND_HI: pass = c && !z;
      COND_LS: pass = !c || z;
      COND_GE: pass = (n == v);
      COND_LT: pass = (n != v);
      COND_GT: pass = !z && (n == v);
      COND_LE: pass = z || (n != v);
      COND_AL: pass = 1'b1;
      default: pass = 1'b0;
    endcase
    if (!pass) begin
      return '{'0, 1'b0, t.flags_in, ST_SKIP};
    end

    is_test = (t.kind == OP_TST) || (t.kind == OP_TEQ) ||
              (t.kind == OP_CMP) || (t.kind == OP_CMN);
    arith = 1'b1;
    x = t.first_operand;
    y = t.second_operand;
    cin = 1'b0;
    r = '0;
    case (t.kind)
      OP_AND, OP_TST: begin r = t.first_operand & t.second_operand;  arith = 1'b0; end
      OP_EOR, OP_TEQ: begin r = t.first_operand ^ t.second_operand;  arith = 1'b0; end
      OP_ORR:         begin r = t.first_operand | t.second_operand;  arith = 1'b0; end
      OP_MOV:         begin r = t.second_operand;                    arith = 1'b0; end
      OP_BIC:         begin r = t.first_operand & ~t.second_operand; arith = 1'b0; end
      OP_MVN:         begin r = ~t.second_operand;                   arith = 1'b0; end
      OP_SUB, OP_CMP: begin y = ~t.second_operand; cin = 1'b1; end
      OP_RSB:         begin x = t.second_operand; y = ~t.first_operand; cin = 1'b1; end
      OP_ADC:         cin = c;
      OP_SBC:         begin y = ~t.second_operand; cin = c; end
      OP_RSC:         begin x = t.second_operand; y = ~t.first_operand; cin = c; end
      default:        cin = 1'b0;  // ADD, CMN
    endcase

    sum = {1'b0, x} + {1'b0, y} + {{DATA_W{1'b0}}, cin};
    if (arith) begin
      r = sum[DATA_W-1:0];
    end

    o.result = r;
    o.flags_out = t.flags_in;
    if (t.set_flags || is_test) begin
      o.flags_out[FLAG_N] = r[DATA_W-1];
      o.flags_out[FLAG_Z] = (r == '0);
      // arithmetic: C is carry out (NOT borrow), V from sign agreement;
      // logical: C from the shifter, V left alone
      o.flags_out[FLAG_C] = arith ? sum[DATA_W] : t.shifter_carry;
      o.flags_out[FLAG_V] = arith ? ((x[DATA_W-1] == y[DATA_W-1]) && (r[DATA_W-1] != x[DATA_W-1]))
                                  : t.flags_in[FLAG_V];
    end
    o.write_back = !is_test;
    o.status = (!is_test && t.dest_is_pc) ? ST_PC : ST_OK;
    return o;
  endfunction

  // Operand mix biased towards the carry and overflow boundaries.
  function automatic logic [DATA_W-1:0] rand_operand();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return 32'h7FFF_FFFF;
      3:       return 32'h8000_0000;
      4:       return DATA_W'($urandom_range(255));
      5:       return ~DATA_W'($urandom_range(255));
      default: return $urandom;
    endcase
  endfunction

  // Offer one instruction, starting and ending at a falling edge. Random idle
  // cycles go in front; valid stays high across back-to-back transactions.
  task automatic offer_instr(input instr_t t, input logic typed, input alu_res_t res);
    while (src_idle_on && $urandom_range(99) < 30) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid          = 1'b1;
    in_if.kind           = t.kind;
    in_if.cond           = t.cond;
    in_if.set_flags      = t.set_flags;
    in_if.first_operand  = t.first_operand;
    in_if.second_operand = t.second_operand;
    in_if.shifter_carry  = t.shifter_carry;
    in_if.flags_in       = t.flags_in;
    in_if.dest_is_pc     = t.dest_is_pc;
    do @(posedge clk); while (!in_if.ready);
    // accepted on this edge; queue its answer straight away
    pending_results.push_back(typed ? res : dp_execute(t));
    n_sent++;
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Sink side: random back-pressure, plus one long hold-off on request.
  // The hold-off is counted here so the source keeps offering meanwhile.
  // ---------------------------------------------------------------------------
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_if.ready = 1'b0;
        hold_left--;
      end else begin
        out_if.ready = !(rx_stall_on && $urandom_range(99) < 30);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker and watchdog, both on the rising edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result transaction: result %h", out_if.result);
          n_err++;
        end else begin
          want = pending_results.pop_front();
          n_checked++;
          if (want.status == ST_SKIP) n_skipped++;
          if (want.status == ST_PC) n_pc_writes++;
          if (out_if.result !== want.result) begin
            $error("field result: expected %h, got %h", want.result, out_if.result);
            n_err++;
          end
          if (out_if.write_back !== want.write_back) begin
            $error("field write_back: expected %b, got %b", want.write_back, out_if.write_back);
            n_err++;
          end
          if (out_if.flags_out !== want.flags_out) begin
            $error("field flags_out: expected %b, got %b", want.flags_out, out_if.flags_out);
            n_err++;
          end
          if (out_if.status !== want.status) begin
            $error("field status: expected %0d, got %0d", want.status, out_if.status);
            n_err++;
          end
        end
      end

      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("watchdog: %0d cycles without a transaction, %0d results outstanding",
                   quiet_cycles, pending_results.size());
          $display("FAILED: results differ");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus: reset, directed table, then random instructions.
  // ---------------------------------------------------------------------------
  initial begin
    instr_t t;
    int i;

    in_if.valid          = 1'b0;
    in_if.kind           = OP_AND;
    in_if.cond           = COND_AL;
    in_if.set_flags      = 1'b0;
    in_if.first_operand  = '0;
    in_if.second_operand = '0;
    in_if.shifter_carry  = 1'b0;
    in_if.flags_in       = '0;
    in_if.dest_is_pc     = 1'b0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (i = 0; i < DIR_ROWS; i++) begin
      offer_instr(dir_tab[i].ins, dir_tab[i].typed, dir_tab[i].res);
    end

    for (i = 0; i < RAND_ITEMS; i++) begin
      // a long clean stretch with no idling on either side
      if (i == 400) begin
        src_idle_on = 1'b0;
        rx_stall_on = 1'b0;
      end
      if (i == 650) begin
        src_idle_on = 1'b1;
        rx_stall_on = 1'b1;
      end
      // sink holds off while the source streams: the pipe fills and stalls in_chan
      if (i == 800) begin
        src_idle_on = 1'b0;
        hold_req = 1'b1;
      end
      if (i == 860) src_idle_on = 1'b1;

      t.kind           = OPC_W'($urandom_range(15));
      t.cond           = ($urandom_range(99) < 45) ? COND_AL : COND_W'($urandom_range(15));
      t.set_flags      = 1'($urandom_range(1));
      t.first_operand  = rand_operand();
      t.second_operand = rand_operand();
      t.shifter_carry  = 1'($urandom_range(1));
      t.flags_in       = FLAG_W'($urandom_range(15));
      t.dest_is_pc     = ($urandom_range(99) < 15);
      offer_instr(t, 1'b0, '0);
    end
    in_if.valid = 1'b0;

    // drain: the watchdog bounds this wait
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d instructions (%0d directed, %0d random) and %0d results checked;",
             n_sent, DIR_ROWS, RAND_ITEMS, n_checked);
    $display("%0d were skipped by their condition and %0d wrote the PC.",
             n_skipped, n_pc_writes);
    if (n_err == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/dpalu_pkg.sv
hw/rtl/dpalu_if.sv
hw/rtl/dpalu_exec.sv
hw/rtl/arm_data_processing_alu_unit.sv
tb/arm_data_processing_alu_unit_tb.sv
